### hw/rtl/bfwf_pkg.sv
// ----------------------------------------------------------------------------
// bfwf_pkg: shared constants and types of the byte FIFO
// Ring depth, widths, register map, mode and flag codes, status struct.
// ----------------------------------------------------------------------------
`default_nettype none

package bfwf_pkg;

   // physical ring depth and derived widths
   localparam int DEPTH  = 256;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   // field widths fixed by the register and beat layout
   localparam int BYTE_W  = 8;
   localparam int FLAGS_W = 3;
   localparam int CSR_DW  = 32;
   localparam int CSR_AW  = 4;
   localparam int REG_IW  = 2;

   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

   // register indexes (byte address 4*i)
   localparam logic [REG_IW-1:0] REG_SIZE_IN_USE = 2'd0;
   localparam logic [REG_IW-1:0] REG_WATERMARK   = 2'd1;
   localparam logic [REG_IW-1:0] REG_IRQ_ENABLE  = 2'd2;

   localparam logic [CNT_W-1:0]   SIZE_RESET = 9'd256;

   // beat opcodes
   localparam logic MODE_PUT = 1'b0;
   localparam logic MODE_GET = 1'b1;

   // status flag bit positions
   localparam int FLAG_LOW_BIT  = 0;
   localparam int FLAG_HIGH_BIT = 1;
   localparam int FLAG_OVF_BIT  = 2;

   typedef struct packed {
      logic [FLAGS_W-1:0] flags;
      logic               irq;
   } bfwf_status_type;

endpackage

`default_nettype wire

### hw/rtl/bfwf_ram.sv
// ----------------------------------------------------------------------------
// bfwf_ram: generic simple dual-port RAM
// One write port, one read port with enable, read data registered.
// ----------------------------------------------------------------------------
`default_nettype none

module bfwf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic                     rd_en,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

### hw/rtl/bfwf_status.sv
// ----------------------------------------------------------------------------
// bfwf_status: watermark flags and interrupt request
// Derives low, high and overflow flags from the level after a beat.
// ----------------------------------------------------------------------------
`default_nettype none

module bfwf_status
   import bfwf_pkg::*;
(
   input  wire logic [CNT_W-1:0]   level,
   input  wire logic [CNT_W-1:0]   ring_size,
   input  wire logic [CNT_W-1:0]   watermark,
   input  wire logic               overflow,
   input  wire logic [FLAGS_W-1:0] irq_enable,
   output bfwf_status_type         status
);

   logic [CNT_W-1:0] free_space;

   always_comb begin
      // a shrunk ring can hold more than it wraps at: no free space then
      free_space = (level >= ring_size) ? '0 : (ring_size - level);
      status.flags                = '0;
      status.flags[FLAG_LOW_BIT]  = (level <= watermark);
      status.flags[FLAG_HIGH_BIT] = (free_space >= watermark);
      status.flags[FLAG_OVF_BIT]  = overflow;
      status.irq                  = |(status.flags & irq_enable);
   end

endmodule

`default_nettype wire

### hw/rtl/byte_fifo_with_watermark_flags_core.sv
// ----------------------------------------------------------------------------
// byte_fifo_with_watermark_flags_core: byte ring FIFO with watermark flags
// Put/get one byte per beat into a RAM ring, report level and status flags.
// ----------------------------------------------------------------------------
// Pipeline: an accepted beat does its RAM read and loads the pending stage,
//    then moves into the response register once that is empty or being taken.
// Throughput: one beat per cycle while the response is not stalled; the pointers
//    and fill count update in flops at accept, so puts and gets reach the RAM back to back.
// Reset: synchronous, active high; pointers, count, overflow and registers
//    return to their defaults, RAM contents are left as they are.
`default_nettype none

module byte_fifo_with_watermark_flags_core
   import bfwf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   // request channel
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic               req_mode,
   input  wire logic [BYTE_W-1:0]  req_write_byte,
   // response channel
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic      [BYTE_W-1:0]  rsp_read_byte,
   output logic                    rsp_done_res,
   output logic      [CNT_W-1:0]   rsp_level,
   output logic      [FLAGS_W-1:0] rsp_status_flags,
   output logic                    rsp_irq_request,
   // register port
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [CSR_AW-1:0]  csr_paddr,
   input  wire logic [CSR_DW-1:0]  csr_pwdata,
   output logic      [CSR_DW-1:0]  csr_prdata,
   output logic                    csr_pready
);

   // ---------------------------------------------------------------- registers
   logic [CNT_W-1:0]   size_ff, size_in;
   logic [CNT_W-1:0]   wm_ff, wm_in;
   logic [FLAGS_W-1:0] irq_en_ff, irq_en_in;
   logic               csr_wr;
   logic [REG_IW-1:0]  csr_idx;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_idx    = csr_paddr[CSR_AW-1:2];

   always_comb begin
      size_in   = size_ff;
      wm_in     = wm_ff;
      irq_en_in = irq_en_ff;
      if (csr_wr) begin
         case (csr_idx)
            REG_SIZE_IN_USE: size_in   = csr_pwdata[CNT_W-1:0];
            REG_WATERMARK:   wm_in     = csr_pwdata[CNT_W-1:0];
            REG_IRQ_ENABLE:  irq_en_in = csr_pwdata[FLAGS_W-1:0];
            default: ;       // unmapped offsets ignore writes
         endcase
      end
   end

   always_comb begin
      case (csr_idx)
         REG_SIZE_IN_USE: csr_prdata = CSR_DW'(size_ff);
         REG_WATERMARK:   csr_prdata = CSR_DW'(wm_ff);
         REG_IRQ_ENABLE:  csr_prdata = CSR_DW'(irq_en_ff);
         default:         csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------- ring state
   logic [ADDR_W-1:0] wp_ff, wp_in;
   logic [ADDR_W-1:0] rp_ff, rp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              ovf_ff, ovf_in;
   logic [CNT_W-1:0]  ring_size;
   logic [CNT_W-1:0]  wp_inc, rp_inc;
   logic              full, req_fire, put_ok, get_ok;

   // size 0 behaves as 1, anything above the RAM depth as the depth
   always_comb begin
      if (size_ff == '0) begin
         ring_size = CNT_W'(1);
      end else if (size_ff > DEPTH_CNT) begin
         ring_size = DEPTH_CNT;
      end else begin
         ring_size = size_ff;
      end
   end

   assign full     = (cnt_ff >= ring_size);
   assign req_fire = req_valid && req_ready;
   assign put_ok   = (req_mode == MODE_PUT) && !full;
   assign get_ok   = (req_mode == MODE_GET) && (cnt_ff != '0);
   assign wp_inc   = {1'b0, wp_ff} + CNT_W'(1);
   assign rp_inc   = {1'b0, rp_ff} + CNT_W'(1);

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      ovf_in = ovf_ff;
      if (req_fire) begin
         if (put_ok) begin
            // pointer wraps at the ring size, even if it sits past a new size
            wp_in  = (wp_inc >= ring_size) ? '0 : wp_inc[ADDR_W-1:0];
            cnt_in = cnt_ff + CNT_W'(1);
         end else if (get_ok) begin
            rp_in  = (rp_inc >= ring_size) ? '0 : rp_inc[ADDR_W-1:0];
            cnt_in = cnt_ff - CNT_W'(1);
         end
         if ((req_mode == MODE_PUT) && full) begin
            ovf_in = 1'b1;     // sticky until reset
         end
      end
   end

   // ---------------------------------------------------------------- byte store
   logic [BYTE_W-1:0] ram_rdata;

   bfwf_ram #(
      .WIDTH (BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (req_fire && put_ok),
      .wr_addr (wp_ff),
      .wr_data (req_write_byte),
      .rd_en   (req_fire && get_ok),
      .rd_addr (rp_ff),
      .rd_data (ram_rdata)
   );

   // ---------------------------------------------------------------- flags
   bfwf_status_type step_status;

   bfwf_status u_status (
      .level      (cnt_in),
      .ring_size  (ring_size),
      .watermark  (wm_ff),
      .overflow   (ovf_in),
      .irq_enable (irq_en_ff),
      .status     (step_status)
   );

   // ---------------------------------------------------------------- pending stage
   // Holds a beat while its RAM read completes. The RAM is read only at
   // accept, so rd_data stays put while this stage stalls.
   logic            pend_ff, pend_in;
   logic            pend_get_ff, pend_get_in;
   logic            pend_done_ff, pend_done_in;
   logic [CNT_W-1:0] pend_level_ff, pend_level_in;
   bfwf_status_type pend_status_ff, pend_status_in;
   logic            move;

   assign move      = pend_ff && (!rsp_valid || rsp_ready);
   assign req_ready = !pend_ff || move;

   always_comb begin
      pend_in        = pend_ff;
      pend_get_in    = pend_get_ff;
      pend_done_in   = pend_done_ff;
      pend_level_in  = pend_level_ff;
      pend_status_in = pend_status_ff;
      if (move) begin
         pend_in = 1'b0;
      end
      if (req_fire) begin
         pend_in        = 1'b1;
         pend_get_in    = get_ok;
         pend_done_in   = put_ok || get_ok;
         pend_level_in  = cnt_in;
         pend_status_in = step_status;
      end
   end

   // ---------------------------------------------------------------- response
   logic              rsp_valid_ff, rsp_valid_in;
   logic [BYTE_W-1:0] rsp_byte_ff, rsp_byte_in;
   logic              rsp_done_ff, rsp_done_in;
   logic [CNT_W-1:0]  rsp_level_ff, rsp_level_in;
   bfwf_status_type   rsp_status_ff, rsp_status_in;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      rsp_byte_in   = rsp_byte_ff;
      rsp_done_in   = rsp_done_ff;
      rsp_level_in  = rsp_level_ff;
      rsp_status_in = rsp_status_ff;
      if (move) begin
         rsp_valid_in  = 1'b1;
         rsp_byte_in   = pend_get_ff ? ram_rdata : '0;
         rsp_done_in   = pend_done_ff;
         rsp_level_in  = pend_level_ff;
         rsp_status_in = pend_status_ff;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_byte    = rsp_byte_ff;
   assign rsp_done_res     = rsp_done_ff;
   assign rsp_level        = rsp_level_ff;
   assign rsp_status_flags = rsp_status_ff.flags;
   assign rsp_irq_request  = rsp_status_ff.irq;

   // ---------------------------------------------------------------- flops
   always_ff @(posedge clock) begin
      if (reset) begin
         size_ff      <= SIZE_RESET;
         wm_ff        <= '0;
         irq_en_ff    <= '0;
         wp_ff        <= '0;
         rp_ff        <= '0;
         cnt_ff       <= '0;
         ovf_ff       <= 1'b0;
         pend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         size_ff      <= size_in;
         wm_ff        <= wm_in;
         irq_en_ff    <= irq_en_in;
         wp_ff        <= wp_in;
         rp_ff        <= rp_in;
         cnt_ff       <= cnt_in;
         ovf_ff       <= ovf_in;
         pend_ff      <= pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_get_ff    <= pend_get_in;
      pend_done_ff   <= pend_done_in;
      pend_level_ff  <= pend_level_in;
      pend_status_ff <= pend_status_in;
      rsp_byte_ff    <= rsp_byte_in;
      rsp_done_ff    <= rsp_done_in;
      rsp_level_ff   <= rsp_level_in;
      rsp_status_ff  <= rsp_status_in;
   end

   // ---------------------------------------------------------------- checks
   a_cnt_bound: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= DEPTH_CNT)
      else $error("fill count above ring depth");

   a_ovf_sticky: assert property (@(posedge clock) disable iff (reset)
      ovf_ff |=> ovf_ff)
      else $error("overflow flag cleared without reset");

   a_stall_blocks: assert property (@(posedge clock) disable iff (reset)
      (pend_ff && rsp_valid_ff && !rsp_ready) |-> !req_ready)
      else $error("request taken while pending beat is stalled");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_done_ff) |-> (rsp_byte_ff == '0))
      else $error("failed beat returned a nonzero byte");

   a_ovf_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (!rsp_status_ff.flags[FLAG_OVF_BIT] || ovf_ff))
      else $error("response shows overflow not recorded");

endmodule

`default_nettype wire

### verif/bfwf_reply_checker.sv
// ----------------------------------------------------------------------------
// bfwf_reply_checker: response checker for the byte FIFO core
// Watches request, response and register traffic, keeps its own copy of the
// ring, and compares every response beat field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module bfwf_reply_checker
   import bfwf_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   input  wire logic               req_ready,
   input  wire logic               req_mode,
   input  wire logic [BYTE_W-1:0]  req_write_byte,
   input  wire logic               rsp_valid,
   input  wire logic               rsp_ready,
   input  wire logic [BYTE_W-1:0]  rsp_read_byte,
   input  wire logic               rsp_done_res,
   input  wire logic [CNT_W-1:0]   rsp_level,
   input  wire logic [FLAGS_W-1:0] rsp_status_flags,
   input  wire logic               rsp_irq_request,
   input  wire logic               csr_psel,
   input  wire logic               csr_penable,
   input  wire logic               csr_pwrite,
   input  wire logic [CSR_AW-1:0]  csr_paddr,
   input  wire logic [CSR_DW-1:0]  csr_pwdata,
   input  wire logic               csr_pready,
   output int                      mismatches,
   output int                      outstanding,
   output int                      responses_checked
);

   typedef struct packed {
      logic [BYTE_W-1:0]  read_byte;
      logic               done;
      logic [CNT_W-1:0]   level;
      logic [FLAGS_W-1:0] flags;
      logic               irq;
   } fifo_reply_type;

   logic [BYTE_W-1:0]  ring_copy [DEPTH];
   logic [ADDR_W-1:0]  put_at;
   logic [ADDR_W-1:0]  take_at;
   logic [CNT_W-1:0]   held;
   logic               overflowed;
   logic [CNT_W-1:0]   span_reg;
   logic [CNT_W-1:0]   mark_reg;
   logic [FLAGS_W-1:0] irq_mask;
   fifo_reply_type     replies_due [$];
   int                 n_bad = 0;
   int                 n_checked = 0;

   task automatic note_mismatch(string what, int got, int want);
      $display("[%0t] mismatch %s: got %0d, want %0d", $realtime, what, got, want);
      n_bad++;
   endtask

   // zero acts as one entry, codes above the ring depth act as the depth
   function automatic logic [CNT_W-1:0] live_span();
      if (span_reg == '0)
         return CNT_W'(1);
      if (span_reg > DEPTH_CNT)
         return DEPTH_CNT;
      return span_reg;
   endfunction

   // a pointer past the end still uses its slot, then wraps to 0
   function automatic logic [ADDR_W-1:0] bump(logic [ADDR_W-1:0] p, logic [CNT_W-1:0] s);
      logic [CNT_W-1:0] n;
      n = CNT_W'(p) + CNT_W'(1);
      return (n >= s) ? '0 : n[ADDR_W-1:0];
   endfunction

   function automatic fifo_reply_type step_fifo(logic mode, logic [BYTE_W-1:0] wb);
      fifo_reply_type   r;
      logic [CNT_W-1:0] s;
      logic [CNT_W-1:0] room;
      s = live_span();
      r = '0;
      if (mode == MODE_PUT) begin
         if (held >= s) begin
            overflowed = 1'b1;
         end else begin
            ring_copy[put_at] = wb;
            put_at = bump(put_at, s);
            held = held + CNT_W'(1);
            r.done = 1'b1;
         end
      end else if (held != '0) begin
         r.read_byte = ring_copy[take_at];
         take_at = bump(take_at, s);
         held = held - CNT_W'(1);
         r.done = 1'b1;
      end
      room = (held >= s) ? '0 : s - held;
      r.flags[FLAG_LOW_BIT]  = (held <= mark_reg);
      r.flags[FLAG_HIGH_BIT] = (room >= mark_reg);
      r.flags[FLAG_OVF_BIT]  = overflowed;
      r.level = held;
      r.irq = |(r.flags & irq_mask);
      return r;
   endfunction

   always @(posedge clock) begin
      fifo_reply_type want;
      if (reset) begin
         put_at = '0;
         take_at = '0;
         held = '0;
         overflowed = 1'b0;
         span_reg = SIZE_RESET;
         mark_reg = '0;
         irq_mask = '0;
         replies_due.delete();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (replies_due.size() == 0) begin
               note_mismatch("response with none outstanding, level", int'(rsp_level), -1);
            end else begin
               want = replies_due.pop_front();
               n_checked++;
               if (rsp_read_byte !== want.read_byte)
                  note_mismatch("read_byte", int'(rsp_read_byte), int'(want.read_byte));
               if (rsp_done_res !== want.done)
                  note_mismatch("done_res", int'(rsp_done_res), int'(want.done));
               if (rsp_level !== want.level)
                  note_mismatch("level", int'(rsp_level), int'(want.level));
               if (rsp_status_flags !== want.flags)
                  note_mismatch("status_flags", int'(rsp_status_flags), int'(want.flags));
               if (rsp_irq_request !== want.irq)
                  note_mismatch("irq_request", int'(rsp_irq_request), int'(want.irq));
            end
         end
         if (csr_psel && csr_penable && csr_pwrite && csr_pready) begin
            case (csr_paddr[REG_IW+1:2])
               REG_SIZE_IN_USE: span_reg = csr_pwdata[CNT_W-1:0];
               REG_WATERMARK:   mark_reg = csr_pwdata[CNT_W-1:0];
               REG_IRQ_ENABLE:  irq_mask = csr_pwdata[FLAGS_W-1:0];
               default: ;
            endcase
         end
         if (req_valid && req_ready)
            replies_due.push_back(step_fifo(req_mode, req_write_byte));
      end
      mismatches <= n_bad;
      outstanding <= replies_due.size();
      responses_checked <= n_checked;
   end

endmodule

`default_nettype wire

### verif/byte_fifo_with_watermark_flags_core_tb.sv
// ----------------------------------------------------------------------------
// byte_fifo_with_watermark_flags_core_tb: stimulus and verdict for the FIFO
// Drives put/get beats and register writes with random gaps and stalls;
// a separate checker predicts and compares every response beat.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_fifo_with_watermark_flags_core_tb;
   import bfwf_pkg::*;

   // address 12 decodes to no register; a write there must change nothing
   localparam logic [REG_IW-1:0] REG_UNMAPPED = 2'd3;
   localparam int LONG_HOLD = 300;      // receiver hold-off, in cycles

   logic               clock;
   logic               reset;
   logic               req_valid;
   logic               req_ready;
   logic               req_mode;
   logic [BYTE_W-1:0]  req_write_byte;
   logic               rsp_valid;
   logic               rsp_ready;
   logic [BYTE_W-1:0]  rsp_read_byte;
   logic               rsp_done_res;
   logic [CNT_W-1:0]   rsp_level;
   logic [FLAGS_W-1:0] rsp_status_flags;
   logic               rsp_irq_request;
   logic               csr_psel;
   logic               csr_penable;
   logic               csr_pwrite;
   logic [CSR_AW-1:0]  csr_paddr;
   logic [CSR_DW-1:0]  csr_pwdata;
   logic [CSR_DW-1:0]  csr_prdata;
   logic               csr_pready;

   int mismatches;
   int outstanding;
   int responses_checked;

   // stimulus bookkeeping: occupancy as seen by the sender, to steer puts
   // away from a full ring until the overflow part of the run
   logic [CNT_W-1:0] cur_size = SIZE_RESET;
   int  occ = 0;
   int  beats_sent = 0;
   int  csr_writes = 0;
   int  hold_asked = 0;
   int  hold_served = 0;
   bit  quiet = 1'b0;                   // no gaps on either side

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   byte_fifo_with_watermark_flags_core uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_mode         (req_mode),
      .req_write_byte   (req_write_byte),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_byte    (rsp_read_byte),
      .rsp_done_res     (rsp_done_res),
      .rsp_level        (rsp_level),
      .rsp_status_flags (rsp_status_flags),
      .rsp_irq_request  (rsp_irq_request),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   bfwf_reply_checker chk (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_mode          (req_mode),
      .req_write_byte    (req_write_byte),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_read_byte     (rsp_read_byte),
      .rsp_done_res      (rsp_done_res),
      .rsp_level         (rsp_level),
      .rsp_status_flags  (rsp_status_flags),
      .rsp_irq_request   (rsp_irq_request),
      .csr_psel          (csr_psel),
      .csr_penable       (csr_penable),
      .csr_pwrite        (csr_pwrite),
      .csr_paddr         (csr_paddr),
      .csr_pwdata        (csr_pwdata),
      .csr_pready        (csr_pready),
      .mismatches        (mismatches),
      .outstanding       (outstanding),
      .responses_checked (responses_checked)
   );

   // mostly short gaps, now and then a long one
   function automatic int pick_gap();
      return ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
   endfunction

   // ring size the block actually uses for a register code
   function automatic int span_of(logic [CNT_W-1:0] raw);
      if (raw == '0)
         return 1;
      if (raw > DEPTH_CNT)
         return DEPTH;
      return int'(raw);
   endfunction

   // small rings fill and drain quickly, so most phases use them
   function automatic logic [CNT_W-1:0] pick_span();
      case ($urandom_range(0, 9))
         0:       return CNT_W'($urandom_range(13, 256));
         1:       return ($urandom_range(0, 1) == 0) ? '0 : CNT_W'($urandom_range(257, 511));
         default: return CNT_W'($urandom_range(1, 12));
      endcase
   endfunction

   function automatic logic [CNT_W-1:0] pick_mark(logic [CNT_W-1:0] raw);
      int e;
      e = span_of(raw);
      case ($urandom_range(0, 7))
         0:       return '0;
         1:       return '1;
         2:       return CNT_W'(e);
         default: return CNT_W'($urandom_range(0, e + 1));
      endcase
   endfunction

   // random junk above the field so the register masks get exercised
   function automatic logic [CSR_DW-1:0] pad_noise(logic [CSR_DW-1:0] v, int w);
      logic [CSR_DW-1:0] keep;
      keep = (CSR_DW'(1) << w) - 1;
      return ($urandom & ~keep) | (v & keep);
   endfunction

   // One beat. With no gap afterwards valid stays high, and the caller must
   // issue the next beat (or drain_wait) in the same time step.
   task automatic send_beat(logic m, logic [BYTE_W-1:0] b);
      int gap;
      req_mode <= m;
      req_write_byte <= b;
      req_valid <= 1'b1;
      do
         @(posedge clock);
      while (!req_ready);
      beats_sent++;
      if (m == MODE_PUT) begin
         if (occ < span_of(cur_size))
            occ++;
      end else if (occ > 0) begin
         occ--;
      end
      if (!quiet && $urandom_range(0, 3) == 0) begin
         gap = pick_gap();
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // random puts and gets; without overflow a put into a full ring becomes a get
   task automatic send_random(int n, int put_pct, bit allow_ovf);
      logic m;
      for (int i = 0; i < n; i++) begin
         m = ($urandom_range(1, 100) <= put_pct) ? MODE_PUT : MODE_GET;
         if (!allow_ovf && m == MODE_PUT && occ >= span_of(cur_size))
            m = MODE_GET;
         send_beat(m, BYTE_W'($urandom));
      end
   endtask

   // stop offering beats until every response is back, plus a latency margin;
   // the checker's count is registered, so look at it only after an edge
   task automatic drain_wait();
      req_valid <= 1'b0;
      @(posedge clock);
      while (outstanding != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   // setup cycle, access cycle, then back to idle so psel never toggles
   // twice in one step
   task automatic write_reg(logic [REG_IW-1:0] idx, logic [CSR_DW-1:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= CSR_AW'({idx, 2'b00});
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      do
         @(posedge clock);
      while (!csr_pready);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      if (idx == REG_SIZE_IN_USE)
         cur_size = data[CNT_W-1:0];
      csr_writes++;
      @(posedge clock);
   endtask

   task automatic configure(logic [CNT_W-1:0] span, logic [CNT_W-1:0] mark,
                            logic [FLAGS_W-1:0] mask);
      drain_wait();
      write_reg(REG_SIZE_IN_USE, pad_noise(CSR_DW'(span), CNT_W));
      write_reg(REG_WATERMARK, pad_noise(CSR_DW'(mark), CNT_W));
      write_reg(REG_IRQ_ENABLE, pad_noise(CSR_DW'(mask), FLAGS_W));
   endtask

   // receiver: random ready pattern, a long hold-off on request
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_asked != hold_served) begin
            rsp_ready <= 1'b0;
            repeat (LONG_HOLD) @(posedge clock);
            hold_served++;
         end else if (quiet || $urandom_range(0, 3) != 0) begin
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b0;
            repeat (pick_gap()) @(posedge clock);
         end
      end
   end

   // stimulus
   initial begin
      logic [CNT_W-1:0] span;
      reset <= 1'b1;
      req_valid <= 1'b0;
      req_mode <= MODE_PUT;
      req_write_byte <= '0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset settings: get from empty, byte extremes through the ring
      send_beat(MODE_GET, 8'hA5);
      send_beat(MODE_PUT, 8'h00);
      send_beat(MODE_PUT, 8'hFF);
      send_beat(MODE_GET, 8'h00);
      send_beat(MODE_GET, 8'hFF);
      send_beat(MODE_GET, 8'h5A);

      // fill the whole ring to level 256 and drain it, receiver held off at
      // first so the input backs up; afterwards every slot has been written
      configure(SIZE_RESET, 9'd256, 3'd3);
      hold_asked++;
      for (int i = 0; i < DEPTH; i++)
         send_beat(MODE_PUT, BYTE_W'($urandom));
      for (int i = 0; i < DEPTH; i++)
         send_beat(MODE_GET, BYTE_W'($urandom));

      // size code zero behaves as a one-entry ring
      configure(9'd0, 9'd1, 3'd1);
      send_beat(MODE_PUT, 8'h3C);
      send_beat(MODE_GET, 8'h00);
      send_beat(MODE_GET, 8'h00);
      send_beat(MODE_PUT, 8'hC3);
      send_beat(MODE_GET, 8'h00);

      // oversized code, watermark at its top value; unmapped address ignored
      configure(9'd511, 9'd511, 3'd2);
      write_reg(REG_UNMAPPED, $urandom);
      send_beat(MODE_PUT, 8'h81);
      send_beat(MODE_GET, 8'h7E);

      // shrink while holding data: write pointer ends up past the new end,
      // the ring counts as full, then both pointers wrap early
      configure(9'd8, 9'd2, 3'd7);
      for (int i = 0; i < 6; i++)
         send_beat(MODE_PUT, BYTE_W'($urandom));
      send_beat(MODE_GET, 8'h00);
      send_beat(MODE_GET, 8'h00);
      configure(9'd3, 9'd1, 3'd3);
      for (int i = 0; i < 4; i++)
         send_beat(MODE_GET, BYTE_W'($urandom));
      send_beat(MODE_PUT, 8'h11);
      send_beat(MODE_PUT, 8'hEE);
      send_beat(MODE_GET, 8'h00);
      send_beat(MODE_GET, 8'h00);

      // random traffic, no overflow yet so the sticky flag stays clear
      for (int k = 0; k < 6; k++) begin
         span = pick_span();
         configure(span, pick_mark(span), FLAGS_W'($urandom_range(0, 7)));
         quiet = (k == 2);
         send_random(60, $urandom_range(25, 75), 1'b0);
      end
      quiet = 1'b0;

      // overflow: put into a full two-entry ring, then empty it and get again
      while (occ > 0)
         send_beat(MODE_GET, BYTE_W'($urandom));
      configure(9'd2, 9'd1, 3'd4);
      send_beat(MODE_PUT, 8'h12);
      send_beat(MODE_PUT, 8'h34);
      send_beat(MODE_PUT, 8'h56);
      send_beat(MODE_GET, 8'h00);
      send_beat(MODE_GET, 8'h00);
      send_beat(MODE_GET, 8'h00);

      // random traffic with overflow allowed
      for (int k = 0; k < 8; k++) begin
         if (k == 3) begin
            configure(SIZE_RESET, pick_mark(SIZE_RESET), FLAGS_W'($urandom_range(0, 7)));
            hold_asked++;
            send_random(60, 85, 1'b1);
         end else begin
            span = pick_span();
            configure(span, pick_mark(span), FLAGS_W'($urandom_range(0, 7)));
            quiet = (k == 5);
            send_random(50, $urandom_range(20, 80), 1'b1);
         end
      end
      quiet = 1'b0;

      drain_wait();
      repeat (8) @(posedge clock);
      $display("Run covered %0d beats, %0d responses checked, %0d register writes",
               beats_sent, responses_checked, csr_writes);
      $display("Ring sizes 1..256 incl. zero and oversized codes, shrink with data, overflow");
      if (mismatches == 0 && outstanding == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // watchdog
   initial begin
      #5000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

`default_nettype wire

### byte_fifo_with_watermark_flags_core.f
hw/rtl/bfwf_pkg.sv
hw/rtl/bfwf_ram.sv
hw/rtl/bfwf_status.sv
hw/rtl/byte_fifo_with_watermark_flags_core.sv
verif/bfwf_reply_checker.sv
verif/byte_fifo_with_watermark_flags_core_tb.sv
